// ===== src/kmsd_pkg.sv =====
`timescale 1ns / 1ps

package kmsd_pkg;

   localparam int ROW_COUNT    = 14;
   localparam int COLUMN_COUNT = 8;

   localparam int ROW_W  = 4;
   localparam int COL_W  = 8;
   localparam int TIME_W = 16;
   localparam int DB_W   = 8;

   localparam logic [ROW_W-1:0] LAST_ROW       = ROW_W'(ROW_COUNT - 1);
   localparam logic [ROW_W-1:0] ROW_LIMIT      = ROW_W'(ROW_COUNT);
   localparam logic [COL_W-1:0] COL_MASK       = COL_W'((64'd1 << COLUMN_COUNT) - 64'd1);
   localparam logic [DB_W-1:0]  DEBOUNCE_RESET = DB_W'(5);

   typedef struct packed {
      logic [ROW_W-1:0]  row_index;
      logic [COL_W-1:0]  column_bits;
      logic [TIME_W-1:0] time_ms;
   } item_type;

   typedef struct packed {
      logic [ROW_W-1:0] row_number;
      logic [COL_W-1:0] debounced_bits;
      logic             committed;
      logic             settling;
   } result_type;

endpackage

// ===== src/kmsd_ifs.sv =====
`timescale 1ns / 1ps

interface kmsd_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  row_index;
   logic [7:0]  column_bits;
   logic [15:0] time_ms;

   modport source (output valid, row_index, column_bits, time_ms, input ready);
   modport sink   (input valid, row_index, column_bits, time_ms, output ready);
endinterface

interface kmsd_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] row_number;
   logic [7:0] debounced_bits;
   logic       committed;
   logic       settling;

   modport source (output valid, row_number, debounced_bits, committed, settling,
                   input ready);
   modport sink   (input valid, row_number, debounced_bits, committed, settling,
                   output ready);
endinterface

interface kmsd_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] debounce_ms;

   modport source (output valid, debounce_ms, input ready);
   modport sink   (input valid, debounce_ms, output ready);
endinterface

// ===== src/kmsd_qualify.sv =====
`timescale 1ns / 1ps

module kmsd_qualify
   import kmsd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  item_type        item,
   input  logic [DB_W-1:0] debounce_ms,
   output result_type      result
);

   logic [COL_W-1:0]  pending_ff   [ROW_COUNT];
   logic [COL_W-1:0]  pending_in   [ROW_COUNT];
   logic [COL_W-1:0]  committed_ff [ROW_COUNT];
   logic [COL_W-1:0]  committed_in [ROW_COUNT];
   logic              settling_ff;
   logic              settling_in;
   logic [TIME_W-1:0] change_time_ff;
   logic [TIME_W-1:0] change_time_in;

   logic              in_range;
   logic [COL_W-1:0]  bits;
   logic [COL_W-1:0]  pend_rd;
   logic [COL_W-1:0]  comm_rd;
   logic              changed;
   logic [TIME_W-1:0] elapsed;
   logic              do_commit;

   assign in_range = item.row_index < ROW_LIMIT;
   assign bits     = item.column_bits & COL_MASK;
   assign pend_rd  = in_range ? pending_ff[item.row_index]   : '0;
   assign comm_rd  = in_range ? committed_ff[item.row_index] : '0;
   assign changed  = in_range && (pend_rd != bits);

   always_comb begin
      pending_in     = pending_ff;
      settling_in    = settling_ff;
      change_time_in = change_time_ff;
      if (changed) begin
         pending_in[item.row_index] = bits;
         settling_in                = 1'b1;
         change_time_in             = item.time_ms;
      end
      // wrapping quiet time since the latest change
      elapsed   = TIME_W'(item.time_ms - change_time_in);
      do_commit = in_range && (item.row_index == LAST_ROW) && settling_in
                  && (elapsed > TIME_W'(debounce_ms));
      committed_in = committed_ff;
      if (do_commit) begin
         committed_in = pending_in;
         settling_in  = 1'b0;
      end
   end

   // a commit never coincides with a change of this row, so pend_rd is current
   assign result.row_number     = item.row_index;
   assign result.debounced_bits = do_commit ? pend_rd : comm_rd;
   assign result.committed      = do_commit;
   assign result.settling       = settling_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ROW_COUNT; i++) begin
            pending_ff[i]   <= '0;
            committed_ff[i] <= '0;
         end
         settling_ff    <= 1'b0;
         change_time_ff <= '0;
      end else if (advance) begin
         pending_ff     <= pending_in;
         committed_ff   <= committed_in;
         settling_ff    <= settling_in;
         change_time_ff <= change_time_in;
      end
   end

   a_commit_last_row: assert property (@(posedge clock) disable iff (reset)
      (advance && result.committed) |-> (item.row_index == LAST_ROW))
      else $error("commit on a row other than the last");

   a_commit_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && result.committed) |=> !settling_ff)
      else $error("settling not cleared after commit");

   a_bad_row_quiet: assert property (@(posedge clock) disable iff (reset)
      (advance && !in_range) |=> ($stable(settling_ff) && $stable(change_time_ff)))
      else $error("out of range row changed debounce state");

   a_change_no_commit: assert property (@(posedge clock) disable iff (reset)
      (advance && changed) |-> (!result.committed && result.settling))
      else $error("changed row committed in the same word");

endmodule

// ===== src/key_matrix_scan_debounce.sv =====
// channel   | dir | handshake        | payload
// ----------+-----+------------------+--------------------------------------
// req_port  | in  | valid / ready    | row_index, column_bits, time_ms
// rsp_port  | out | valid / ready    | row_number, debounced_bits,
//           |     |                  | committed, settling
// csr_port  | in  | valid / ready    | debounce_ms (always ready)
//
// One word per cycle sustained while rsp_port is ready; a word passes the input register
// and then the result register, which drives rsp valid.
// The whole matrix commit is a parallel copy of the pending row flops.
// Synchronous active-high reset: empty pipeline, matrices zero, debounce_ms = 5.
// rsp stall holds the result register; the input register still drains into it
// as soon as it empties, and req_ready drops only when both stages are full.
`timescale 1ns / 1ps

module key_matrix_scan_debounce
   import kmsd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   kmsd_req_if.sink  req_port,
   kmsd_rsp_if.source rsp_port,
   kmsd_csr_if.sink  csr_port
);

   logic            in_valid_ff;
   logic            in_valid_in;
   item_type        in_item_ff;
   logic            out_valid_ff;
   logic            out_valid_in;
   result_type      out_result_ff;
   result_type      step_result;
   logic [DB_W-1:0] debounce_ff;
   logic            req_fire;
   logic            advance;

   // item moves from input register to result register
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_port.ready);
   assign req_port.ready = !in_valid_ff || advance;
   assign req_fire = req_port.valid && req_port.ready;

   assign in_valid_in  = req_fire ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_port.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         debounce_ff  <= DEBOUNCE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_port.valid) begin
            debounce_ff <= csr_port.debounce_ms;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff.row_index   <= req_port.row_index;
         in_item_ff.column_bits <= req_port.column_bits;
         in_item_ff.time_ms     <= req_port.time_ms;
      end
      if (advance) begin
         out_result_ff <= step_result;
      end
   end

   kmsd_qualify u_qualify (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .item        (in_item_ff),
      .debounce_ms (debounce_ff),
      .result      (step_result)
   );

   assign csr_port.ready = 1'b1;

   assign rsp_port.valid          = out_valid_ff;
   assign rsp_port.row_number     = out_result_ff.row_number;
   assign rsp_port.debounced_bits = out_result_ff.debounced_bits;
   assign rsp_port.committed      = out_result_ff.committed;
   assign rsp_port.settling       = out_result_ff.settling;

endmodule
